// ----- sv/pqpe_pkg.sv -----
// ----------------------------------------------------------------------------
// pqpe_pkg
// Types and constants shared by the priority queue pool engine
// ----------------------------------------------------------------------------
package pqpe_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 32;
    localparam int PW    = 8;
    localparam int LW    = 5;

    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_DEQ = 2'd1;
    localparam logic [1:0] MODE_REM = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_QUEUE_KIND = 1'b1;

    typedef struct packed {
        logic [1:0]    mode;
        logic [CW-1:0] content;
        logic [PW-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]    status;
        logic [CW-1:0] out_content;
        logic [PW-1:0] out_priority;
        logic [LW-1:0] level;
    } t_result;

endpackage

// ----- sv/pqpe_ram.sv -----
// ----------------------------------------------------------------------------
// pqpe_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module pqpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/priority_queue_pool_engine.sv -----
// ----------------------------------------------------------------------------
// priority_queue_pool_engine
// Linked list priority queue over a fixed pool of node slots
// ----------------------------------------------------------------------------
// Command channel: an item (mode, content, priority) is taken when i_start is
// high and o_busy is low. Each item gives exactly one result on o_result,
// marked by o_valid for one cycle; the receiver cannot stall it.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0 capacity,
// 1 queue kind); write only while idle, the block itself does not enforce it.
// Refused items answer straight from idle. LIFO enqueues, enqueues into an
// empty queue and dequeues pass through one further state (POP or DEQ).
// Ordered enqueue goes through POP and the list walk, plus LINK2 for a middle
// insertion, and remove by content through TCHK and the walk; the walk visits one list node
// a cycle through the registered read port of the node and link RAMs.
// o_busy stays high for the whole item.
// Reset empties the queue, refills the slot pool in order, sets capacity to
// the pool depth and selects ordered mode. The pool needs no clearing pass:
// a low-water mark tells which pool entries still hold their reset slot.
// ----------------------------------------------------------------------------
module priority_queue_pool_engine (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  pqpe_pkg::t_in_item      i_item,
    output logic                    o_busy,
    output logic                    o_valid,
    output pqpe_pkg::t_result       o_result,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [pqpe_pkg::LW-1:0] i_cfg_data
);

    localparam int AW = pqpe_pkg::AW;
    localparam int CW = pqpe_pkg::CW;
    localparam int PW = pqpe_pkg::PW;
    localparam int LW = pqpe_pkg::LW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_DEQ   = 3'd2;
    localparam logic [2:0] S_TCHK  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_LINK2 = 3'd5;

    localparam logic [LW-1:0] FULL_DEPTH = LW'(pqpe_pkg::DEPTH);

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_cap;
    logic          r_kind;
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_c, n_c;
    logic [PW-1:0] r_p, n_p;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [AW-1:0] r_cur, n_cur, r_prev, n_prev, r_s, n_s;
    logic          r_has_prev, n_has_prev, r_hit, n_hit;
    logic [LW-1:0] r_count, n_count, r_fc, n_fc, r_min, n_min, r_i, n_i;
    logic          r_valid;
    pqpe_pkg::t_result r_res;

    logic               fin;
    pqpe_pkg::t_result  res;
    logic [LW-1:0]      full_lvl, fc_m1;
    logic [AW-1:0]      rd_addr, pop_slot;
    logic               node_we, link_we, free_we;
    logic [AW-1:0]      node_wa, link_wa, free_wa;
    logic [CW+PW-1:0]   node_wd, node_rd;
    logic [AW-1:0]      link_wd, link_rd, free_wd, free_rd;
    logic [CW-1:0]      rd_c;
    logic [PW-1:0]      rd_p;
    logic               match;

    assign rd_c     = node_rd[CW+PW-1:PW];
    assign rd_p     = node_rd[PW-1:0];
    assign fc_m1    = r_fc - LW'(1);
    assign pop_slot = (fc_m1 < r_min) ? fc_m1[AW-1:0] : free_rd;
    assign full_lvl = (r_cap == '0) ? LW'(1) : ((r_cap > FULL_DEPTH) ? FULL_DEPTH : r_cap);
    assign match    = r_hit ? (r_cur == r_tail) : (rd_c == r_c);

    pqpe_ram #(.WIDTH(CW + PW), .DEPTH(pqpe_pkg::DEPTH)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(node_wd),
        .i_raddr(rd_addr), .o_rdata(node_rd)
    );

    pqpe_ram #(.WIDTH(AW), .DEPTH(pqpe_pkg::DEPTH)) u_link_ram (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(rd_addr), .o_rdata(link_rd)
    );

    pqpe_ram #(.WIDTH(AW), .DEPTH(pqpe_pkg::DEPTH)) u_free_ram (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_wa), .i_wdata(free_wd),
        .i_raddr(fc_m1[AW-1:0]), .o_rdata(free_rd)
    );

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_c        = r_c;
        n_p        = r_p;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_s        = r_s;
        n_has_prev = r_has_prev;
        n_hit      = r_hit;
        n_count    = r_count;
        n_fc       = r_fc;
        n_min      = r_min;
        n_i        = r_i;
        rd_addr    = r_cur;
        node_we    = 1'b0;
        node_wa    = r_s;
        node_wd    = {r_c, r_p};
        link_we    = 1'b0;
        link_wa    = r_s;
        link_wd    = r_head;
        free_we    = 1'b0;
        free_wa    = r_fc[AW-1:0];
        free_wd    = r_cur;
        fin        = 1'b0;
        res        = '0;
        unique case (r_state)
            S_IDLE: begin
                n_mode = i_item.mode;
                n_c    = i_item.content;
                n_p    = i_item.priority_req;
                if (i_item.mode == pqpe_pkg::MODE_DEQ) begin
                    rd_addr = r_head;
                end else begin
                    rd_addr = r_tail;
                end
                if (i_start) begin
                    case (i_item.mode)
                        pqpe_pkg::MODE_ENQ: begin
                            if (i_item.content == '0) begin
                                fin = 1'b1;
                                res.status = pqpe_pkg::ST_REJECTED;
                            end else if (r_count >= full_lvl || r_fc == '0) begin
                                fin = 1'b1;
                                res.status = pqpe_pkg::ST_FULL;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        pqpe_pkg::MODE_DEQ: begin
                            if (r_count == '0) begin
                                fin = 1'b1;
                                res.status = pqpe_pkg::ST_EMPTY;
                            end else begin
                                n_cur   = r_head;
                                n_state = S_DEQ;
                            end
                        end
                        pqpe_pkg::MODE_REM: begin
                            if (i_item.content == '0 || r_kind) begin
                                fin = 1'b1;
                                res.status = pqpe_pkg::ST_REJECTED;
                            end else if (r_count == '0) begin
                                fin = 1'b1;
                                res.status = pqpe_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_TCHK;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                            res.status = pqpe_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_s     = pop_slot;
                n_fc    = fc_m1;
                n_min   = (fc_m1 < r_min) ? fc_m1 : r_min;
                node_we = 1'b1;
                node_wa = pop_slot;
                link_wa = pop_slot;
                if (r_count == '0) begin
                    n_head = pop_slot;
                    n_tail = pop_slot;
                    n_count = r_count + LW'(1);
                    fin = 1'b1;
                end else if (r_kind) begin
                    link_we = 1'b1;
                    n_head  = pop_slot;
                    n_count = r_count + LW'(1);
                    fin = 1'b1;
                end else begin
                    rd_addr    = r_head;
                    n_cur      = r_head;
                    n_i        = '0;
                    n_has_prev = 1'b0;
                    n_state    = S_WALK;
                end
            end
            S_DEQ: begin
                res.out_content  = rd_c;
                res.out_priority = rd_p;
                n_head  = link_rd;
                n_count = r_count - LW'(1);
                if (n_count == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
                if (r_fc < FULL_DEPTH) begin
                    free_we = 1'b1;
                    n_fc    = r_fc + LW'(1);
                end
                fin = 1'b1;
            end
            S_TCHK: begin
                n_hit      = (rd_c == r_c);
                rd_addr    = r_head;
                n_cur      = r_head;
                n_i        = '0;
                n_has_prev = 1'b0;
                n_state    = S_WALK;
            end
            S_WALK: begin
                rd_addr = link_rd;
                if (r_mode == pqpe_pkg::MODE_ENQ) begin
                    if (r_i == r_count) begin
                        link_we = 1'b1;
                        link_wa = r_tail;
                        link_wd = r_s;
                        n_tail  = r_s;
                        n_count = r_count + LW'(1);
                        fin = 1'b1;
                    end else if (r_p > rd_p) begin
                        if (!r_has_prev) begin
                            link_we = 1'b1;
                            n_head  = r_s;
                            n_count = r_count + LW'(1);
                            fin = 1'b1;
                        end else begin
                            link_we = 1'b1;
                            link_wa = r_prev;
                            link_wd = r_s;
                            n_state = S_LINK2;
                        end
                    end else begin
                        n_prev     = r_cur;
                        n_has_prev = 1'b1;
                        n_cur      = link_rd;
                        n_i        = r_i + LW'(1);
                    end
                end else begin
                    if (r_i == r_count) begin
                        fin = 1'b1;
                        res.status = pqpe_pkg::ST_NOT_FOUND;
                    end else if (match) begin
                        res.out_content  = rd_c;
                        res.out_priority = rd_p;
                        if (!r_has_prev) begin
                            n_head = link_rd;
                        end else begin
                            link_we = 1'b1;
                            link_wa = r_prev;
                            link_wd = link_rd;
                            if (r_cur == r_tail) begin
                                n_tail = r_prev;
                            end
                        end
                        n_count = r_count - LW'(1);
                        if (n_count == '0) begin
                            n_head = '0;
                            n_tail = '0;
                        end
                        if (r_fc < FULL_DEPTH) begin
                            free_we = 1'b1;
                            n_fc    = r_fc + LW'(1);
                        end
                        fin = 1'b1;
                    end else begin
                        n_prev     = r_cur;
                        n_has_prev = 1'b1;
                        n_cur      = link_rd;
                        n_i        = r_i + LW'(1);
                    end
                end
            end
            S_LINK2: begin
                link_we = 1'b1;
                link_wd = r_cur;
                n_count = r_count + LW'(1);
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = S_IDLE;
        end
        res.level = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= FULL_DEPTH;
            r_kind  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_fc    <= FULL_DEPTH;
            r_min   <= FULL_DEPTH;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_fc    <= n_fc;
            r_min   <= n_min;
            r_valid <= fin;
            if (i_cfg_we) begin
                if (i_cfg_index == pqpe_pkg::CFG_CAPACITY) begin
                    r_cap <= i_cfg_data;
                end else begin
                    r_kind <= i_cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_c        <= n_c;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_s        <= n_s;
        r_has_prev <= n_has_prev;
        r_hit      <= n_hit;
        r_i        <= n_i;
        if (fin) begin
            r_res <= res;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTH
    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_count + r_fc) == FULL_DEPTH))
        else $error("slot pool and queue level out of step");
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while still busy");
    a_refused_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.mode == pqpe_pkg::MODE_BAD) |=> o_valid)
        else $error("unknown mode not refused at once");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue keeps stale pointers");
`endif

endmodule
